/* sv/sh24_pkg.sv */
`timescale 1ns / 1ps

package sh24_pkg;

    // Field and port widths.
    localparam int W_WORD  = 64;
    localparam int W_COUNT = 4;
    localparam int W_LEN   = 8;
    localparam int W_PADDR = 4;
    localparam int W_PDATA = 64;

    // Register decode: each key half is 64 bits wide, so registers sit 8 bytes apart.
    localparam int  REG_SEL_BIT  = 3;
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    // Default round counts.
    localparam int C_COMPRESS_ROUNDS = 2;
    localparam int C_FINAL_ROUNDS    = 4;

    // Lane initialization constants.
    localparam logic [W_WORD-1:0] INIT_A = 64'h736f6d6570736575;
    localparam logic [W_WORD-1:0] INIT_B = 64'h646f72616e646f6d;
    localparam logic [W_WORD-1:0] INIT_C = 64'h6c7967656e657261;
    localparam logic [W_WORD-1:0] INIT_D = 64'h7465646279746573;

    // Constant folded into lane c before the final rounds.
    localparam logic [W_WORD-1:0] FINAL_XOR = 64'h00000000000000ff;

    // Position of the length byte in the final block.
    localparam int LEN_POS = 56;

    typedef struct packed {
        logic [W_WORD-1:0] a;
        logic [W_WORD-1:0] b;
        logic [W_WORD-1:0] c;
        logic [W_WORD-1:0] d;
    } t_lanes;

    // One SipRound over the four lanes.
    function automatic t_lanes sip_round(input t_lanes v);
        logic [W_WORD-1:0] a;
        logic [W_WORD-1:0] b;
        logic [W_WORD-1:0] c;
        logic [W_WORD-1:0] d;
        t_lanes res;
        a = v.a + v.b;
        b = {v.b[50:0], v.b[63:51]} ^ a;
        a = {a[31:0], a[63:32]};
        c = v.c + v.d;
        d = {v.d[47:0], v.d[63:48]} ^ c;
        a = a + d;
        d = {d[42:0], d[63:43]} ^ a;
        c = c + b;
        b = {b[46:0], b[63:47]} ^ c;
        c = {c[31:0], c[63:32]};
        res.a = a;
        res.b = b;
        res.c = c;
        res.d = d;
        return res;
    endfunction

endpackage

/* sv/sh24_if.sv */
`timescale 1ns / 1ps

// Request channel: one message word per request.
interface sh24_in_if import sh24_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [W_WORD-1:0]  data_word;
    logic [W_COUNT-1:0] byte_count;
    logic               last;

    modport source (output valid, output data_word, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last,
                    output ready);
endinterface

// Result channel: one digest per message.
interface sh24_out_if import sh24_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [W_WORD-1:0] digest;

    modport source (output valid, output digest, input ready);
    modport sink   (input valid, input digest, output ready);
endinterface

/* sv/sh24_finalize.sv */
`timescale 1ns / 1ps

module sh24_finalize import sh24_pkg::*; #(
    parameter int COMPRESS_ROUNDS = C_COMPRESS_ROUNDS,
    parameter int FINAL_ROUNDS    = C_FINAL_ROUNDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_lanes            i_lanes,
    input  logic [W_WORD-1:0] i_block,
    sh24_out_if.source        o_res
);

    // Stage 0 holds the lanes and the final block; stage 1 holds the lanes after the
    // block is absorbed; each later stage is one more final round.
    logic [FINAL_ROUNDS:0]   r_valid;
    t_lanes                  r_lanes [FINAL_ROUNDS+1];
    logic [W_WORD-1:0]       r_block;
    logic [FINAL_ROUNDS+1:0] w_ready;
    t_lanes                  n_lanes [FINAL_ROUNDS+1];
    t_lanes                  w_first;
    logic                    r_out_valid;
    logic [W_WORD-1:0]       r_digest;
    t_lanes                  w_last_round;

    // A stage can take a request when it is empty or its content moves on.
    assign w_ready[FINAL_ROUNDS+1] = !r_out_valid || o_res.ready;
    genvar k;
    generate
        for (k = 0; k <= FINAL_ROUNDS; k++) begin : g_ready
            assign w_ready[k] = !r_valid[k] || w_ready[k+1];
        end
    endgenerate
    assign o_ready = w_ready[0];

    // Absorb the final block, then fold in the final constant.
    always_comb begin
        t_lanes v;
        v = r_lanes[0];
        v.d = v.d ^ r_block;
        for (int r = 0; r < COMPRESS_ROUNDS; r++) begin
            v = sip_round(v);
        end
        v.a = v.a ^ r_block;
        v.c = v.c ^ FINAL_XOR;
        w_first = v;
    end

    assign n_lanes[0] = i_lanes;
    assign n_lanes[1] = w_first;

    generate
        for (k = 2; k <= FINAL_ROUNDS; k++) begin : g_round
            assign n_lanes[k] = sip_round(r_lanes[k-1]);
        end
    endgenerate

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ready[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int s = 1; s <= FINAL_ROUNDS; s++) begin
                if (w_ready[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[0] && i_valid) begin
            r_lanes[0] <= n_lanes[0];
            r_block    <= i_block;
        end
        for (int s = 1; s <= FINAL_ROUNDS; s++) begin
            if (w_ready[s] && r_valid[s-1]) begin
                r_lanes[s] <= n_lanes[s];
            end
        end
    end

    // Last final round and the lane fold into the output register.
    assign w_last_round = sip_round(r_lanes[FINAL_ROUNDS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[FINAL_ROUNDS+1]) begin
            r_out_valid <= r_valid[FINAL_ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[FINAL_ROUNDS+1] && r_valid[FINAL_ROUNDS]) begin
            r_digest <= w_last_round.a ^ w_last_round.b ^ w_last_round.c ^ w_last_round.d;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.digest = r_digest;

    // A filled stage whose successor is blocked keeps its request.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[FINAL_ROUNDS] && !w_ready[FINAL_ROUNDS+1]) |=> r_valid[FINAL_ROUNDS])
        else $error("final stage lost a request while blocked");

    // The output register only fills from the last stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_valid[FINAL_ROUNDS]))
        else $error("digest appeared without a request in the last stage");

    // The stage chain reports ready whenever the output register is free.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || o_res.ready) |-> o_ready)
        else $error("finalization pipeline stalled with a free output");

endmodule

/* sv/siphash_2_4_digest.sv */
`timescale 1ns / 1ps

// Keyed SipHash-2-4 over a stream of 64-bit little-endian message words.
//
// Program the 128-bit key through the APB port: key_low at byte address 0,
// key_high at byte address 8. The key is sampled when the first word of a
// message is processed, so a write during an open message applies to the next.
// Requests arrive on i_req: data_word, byte_count (valid bytes, used on the last
// word only) and last. One request is accepted per cycle. Each word first lands
// in an input register; the next cycle a non-last word is absorbed into the lane registers
// with COMPRESS_ROUNDS combinational SipRounds, and that feedback loop sets
// the rate of one word per cycle. A last word is handed to a finalization
// pipeline with FINAL_ROUNDS + 1 stages followed by an output register that
// drives o_res. Non-last words produce no result. When o_res is stalled, the
// finalization stages fill up first; only when they are all full does i_req drop
// ready. Reset clears the key, closes any open message and empties the pipeline.
module siphash_2_4_digest import sh24_pkg::*; #(
    parameter int COMPRESS_ROUNDS = C_COMPRESS_ROUNDS,
    parameter int FINAL_ROUNDS    = C_FINAL_ROUNDS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sh24_in_if.sink            i_req,
    sh24_out_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [W_PADDR-1:0] paddr,
    input  logic [W_PDATA-1:0] pwdata,
    output logic [W_PDATA-1:0] prdata,
    output logic               pready
);

    logic [W_WORD-1:0]  r_key_low;
    logic [W_WORD-1:0]  r_key_high;
    logic               r_in_valid;
    logic [W_WORD-1:0]  r_in_word;
    logic [W_COUNT-1:0] r_in_count;
    logic               r_in_last;
    t_lanes             r_lanes;
    logic [W_LEN-1:0]   r_len;
    logic               r_in_msg;
    t_lanes             w_base;
    t_lanes             w_after;
    logic [W_LEN-1:0]   n_len;
    logic [W_WORD-1:0]  w_block;
    logic               w_full;
    logic               w_fire;
    logic               w_fin_ready;
    logic               w_fin_valid;

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[REG_SEL_BIT])
                REG_KEY_LOW:  r_key_low  <= pwdata;
                REG_KEY_HIGH: r_key_high <= pwdata;
                default:      r_key_low  <= r_key_low;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_KEY_LOW:  prdata = r_key_low;
            REG_KEY_HIGH: prdata = r_key_high;
            default:      prdata = '0;
        endcase
    end

    // Input register: a word waits here until the lane loop or, for a last word, the finalization pipeline takes it.
    assign w_fire        = r_in_valid && (!r_in_last || w_fin_ready);
    assign i_req.ready   = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_word  <= i_req.data_word;
            r_in_count <= i_req.byte_count;
            r_in_last  <= i_req.last;
        end
    end

    // Lane loop: start from the key on a new message, then absorb a full word.
    assign w_full = !r_in_last || r_in_count[W_COUNT-1];

    always_comb begin
        t_lanes v;
        logic [W_LEN-1:0] len_base;
        if (r_in_msg) begin
            w_base   = r_lanes;
            len_base = r_len;
        end else begin
            w_base.a = r_key_low  ^ INIT_A;
            w_base.b = r_key_high ^ INIT_B;
            w_base.c = r_key_low  ^ INIT_C;
            w_base.d = r_key_high ^ INIT_D;
            len_base = '0;
        end
        v   = w_base;
        v.d = v.d ^ r_in_word;
        for (int r = 0; r < COMPRESS_ROUNDS; r++) begin
            v = sip_round(v);
        end
        v.a = v.a ^ r_in_word;
        w_after = w_full ? v : w_base;
        if (w_full) begin
            n_len = len_base + W_LEN'(8);
        end else begin
            n_len = len_base + W_LEN'(r_in_count[W_COUNT-2:0]);
        end
    end

    // Final block: leftover bytes below byte_count, length in the top byte.
    always_comb begin
        w_block = '0;
        if (!w_full) begin
            for (int i = 0; i < 7; i++) begin
                if (i < int'(r_in_count[W_COUNT-2:0])) begin
                    w_block[8*i +: 8] = r_in_word[8*i +: 8];
                end
            end
        end
        w_block[LEN_POS +: W_LEN] = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_len    <= '0;
        end else if (w_fire) begin
            r_in_msg <= !r_in_last;
            r_len    <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && !r_in_last) begin
            r_lanes <= w_after;
        end
    end

    // Finalization pipeline for closing words.
    assign w_fin_valid = r_in_valid && r_in_last;

    sh24_finalize #(
        .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
        .FINAL_ROUNDS    (FINAL_ROUNDS)
    ) u_finalize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fin_valid),
        .o_ready (w_fin_ready),
        .i_lanes (w_after),
        .i_block (w_block),
        .o_res   (o_res)
    );

    // A closing word leaves no open message behind.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_last) |=> !r_in_msg)
        else $error("message still open after its last word");

    // A middle word of an open message grows the length by eight.
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !r_in_last && r_in_msg) |=> (r_in_msg && r_len == $past(r_len) + W_LEN'(8)))
        else $error("length did not advance by a full word");

    // A waiting word is neither dropped nor overwritten.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_in_word) && $stable(r_in_last)))
        else $error("input register changed while its word was waiting");

endmodule
